[design/cht_pkg.sv]
// ---------------------------------------------------------------------------
// cht_pkg
// Shared types, codes and constants for the checked handle table.
// ---------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

    // handle layout
    localparam int IDX_W      = 18;
    localparam int TYPE_LSB   = 18;
    localparam int TAG_LSB    = 24;
    localparam int PARITY_BIT = 31;

    localparam int HANDLE_W = 32;
    localparam int TYPE_W   = 6;
    localparam int TAG_W    = 7;
    localparam int OUTIDX_W = 10;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;

    // index compare width, wide enough for any entry count
    localparam int CMP_W = IDX_W + 1;

    // default table size
    localparam int MAX_ENTRIES_DEF = 1024;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBJECT_TYPE = 1'b0,
        CFG_HANDLE_SALT = 1'b1
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_CHECK = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_NULL   = 3'd2,
        ST_PARITY = 3'd3,
        ST_TYPE   = 3'd4,
        ST_RANGE  = 3'd5,
        ST_TAG    = 3'd6
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle_in;
        logic [TAG_W-1:0]    new_tag;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle_out;
        logic [OUTIDX_W-1:0] index_out;
    } t_out_word;

    // table update request from the evaluation logic
    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [TAG_W-1:0] tag;
    } t_tbl_upd;

endpackage

`default_nettype wire

[design/cht_ram.sv]
// ---------------------------------------------------------------------------
// cht_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/cht_eval.sv]
// ---------------------------------------------------------------------------
// cht_eval
// Request evaluation: builds new handles, signals table clears and checks
// incoming handles for null, parity, type, entry count and stored tag.
// ---------------------------------------------------------------------------
`default_nettype none

module cht_eval
    import cht_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  wire t_in_word            i_item,
    input  wire logic [CNT_W-1:0]    i_count,
    input  wire logic [TAG_W-1:0]    i_rd_tag,
    input  wire logic [TYPE_W-1:0]   i_obj_type,
    input  wire logic [HANDLE_W-1:0] i_salt,
    output t_out_word                o_res,
    output t_tbl_upd                 o_upd
);

    logic [HANDLE_W-1:0]   h_plain;
    logic [IDX_W-1:0]      chk_idx;
    logic [TYPE_W-1:0]     chk_type;
    logic [TAG_W-1:0]      chk_tag;
    logic [TAG_W-1:0]      add_tag;
    logic [PARITY_BIT-1:0] add_body;
    logic                  full;
    logic                  in_range;

    // fields of the incoming handle after the salt is removed
    assign h_plain  = i_item.handle_in ^ i_salt;
    assign chk_idx  = h_plain[IDX_W-1:0];
    assign chk_type = h_plain[TAG_LSB-1:TYPE_LSB];
    assign chk_tag  = h_plain[PARITY_BIT-1:TAG_LSB];
    assign in_range = {1'b0, chk_idx} < CMP_W'(i_count);

    // new handle body, zero tag promoted to one
    assign add_tag  = (i_item.new_tag == '0) ? TAG_W'(1) : i_item.new_tag;
    assign add_body = {add_tag, i_obj_type, IDX_W'(i_count)};
    assign full     = i_count >= CNT_W'(MAX_ENTRIES);

    always_comb begin
        o_res = '0;
        o_upd = '0;
        unique case (i_item.mode)
            MODE_ADD: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_res.status     = ST_OK;
                    o_res.handle_out = {^add_body, add_body} ^ i_salt;
                    o_res.index_out  = OUTIDX_W'(i_count);
                    o_upd.wr         = 1'b1;
                    o_upd.tag        = add_tag;
                end
            end
            MODE_CHECK: begin
                // checks in fixed order, first failure wins
                priority if (i_item.handle_in == '0) begin
                    o_res.status = ST_NULL;
                end else if (h_plain[PARITY_BIT] != ^h_plain[PARITY_BIT-1:0]) begin
                    o_res.status = ST_PARITY;
                end else if (chk_type != i_obj_type) begin
                    o_res.status = ST_TYPE;
                end else if (!in_range) begin
                    o_res.status = ST_RANGE;
                end else if (i_rd_tag != chk_tag) begin
                    o_res.status = ST_TAG;
                end else begin
                    o_res.status    = ST_OK;
                    o_res.index_out = chk_idx[OUTIDX_W-1:0];
                end
            end
            MODE_CLEAR: begin
                o_upd.clr = 1'b1;
            end
            default: begin
                // unused mode: no effect, plain ok result
                o_res.status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/checked_handle_table.sv]
// ---------------------------------------------------------------------------
// checked_handle_table
// Issues 32-bit checked handles and validates them against a tag table.
// ---------------------------------------------------------------------------
// Usage:
//   Requests come in on i_in_valid / o_in_stall with i_in_data (mode,
//   handle_in, new_tag); each gives exactly one result word on
//   o_out_valid / i_out_stall with o_out_data (status, handle_out,
//   index_out). Add takes the next free entry, validate checks a handle,
//   clear empties the table.
//   The tag RAM is read at acceptance alongside the request register, and one
//   pass of logic evaluates it into the result register, raising o_out_valid,
//   when that register is free. Requests are sustained at one per cycle while
//   the receiver does not stall, with one tag RAM read and one write per
//   cycle, and a write forwarding register covers an add followed by a check.
//   While the receiver stalls, the result register holds, the request register
//   holds once filled, and o_in_stall rises. Configuration (object type, salt)
//   is written through i_cfg_we; the user must do so only while no request is
//   in flight, which the block does not enforce. Reset empties the table and
//   clears the configuration registers; the tag RAM needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module checked_handle_table
    import cht_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_data
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    logic [TYPE_W-1:0]   r_obj_type;
    logic [HANDLE_W-1:0] r_salt;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_s1_valid, n_s1_valid;
    t_in_word            r_s1;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out;
    logic                r_byp_valid, n_byp_valid;
    logic [ADDR_W-1:0]   r_byp_addr;
    logic [TAG_W-1:0]    r_byp_tag;

    logic                accept;
    logic                adv;
    logic                tbl_we;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   s1_addr;
    logic [TAG_W-1:0]    ram_tag;
    logic [TAG_W-1:0]    cur_tag;
    t_out_word           res;
    t_tbl_upd            upd;

    // handshake
    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign tbl_we     = adv && upd.wr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_type <= '0;
            r_salt     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OBJECT_TYPE: r_obj_type <= i_cfg_data[TYPE_W-1:0];
                CFG_HANDLE_SALT: r_salt     <= i_cfg_data[HANDLE_W-1:0];
                default:         r_salt     <= r_salt;
            endcase
        end
    end

    // tag table, read as the request is taken in
    assign rd_addr = ADDR_W'((i_in_data.handle_in ^ r_salt) & HANDLE_W'((1 << IDX_W) - 1));

    cht_ram #(
        .WIDTH  (TAG_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (upd.tag),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_tag)
    );

    // latest write wins over a read taken at the same edge
    assign s1_addr = ADDR_W'((r_s1.handle_in ^ r_salt) & HANDLE_W'((1 << IDX_W) - 1));
    assign cur_tag = (r_byp_valid && (r_byp_addr == s1_addr)) ? r_byp_tag : ram_tag;

    cht_eval #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_eval (
        .i_item     (r_s1),
        .i_count    (r_count),
        .i_rd_tag   (cur_tag),
        .i_obj_type (r_obj_type),
        .i_salt     (r_salt),
        .o_res      (res),
        .o_upd      (upd)
    );

    // next state of control registers
    always_comb begin
        n_s1_valid  = accept ? 1'b1 : (adv ? 1'b0 : r_s1_valid);
        n_out_valid = adv ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);
        n_byp_valid = r_byp_valid || tbl_we;
        n_count     = r_count;
        if (adv && upd.clr) begin
            n_count = '0;
        end else if (tbl_we) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_byp_valid <= n_byp_valid;
            r_count     <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
        if (tbl_we) begin
            r_byp_addr <= r_count[ADDR_W-1:0];
            r_byp_tag  <= upd.tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[dv/tb_checked_handle_table.sv]
// ---------------------------------------------------------------------------
// tb_checked_handle_table
// Self-checking bench for the checked handle table. A queue of request words
// feeds a driver with random gaps, a monitor with random back-pressure checks
// every response word against a local table model. Runs go through several
// type/salt settings, a full table, stale handles after clear and every
// validation error.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_checked_handle_table;
    import cht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = MAX_ENTRIES_DEF;
    localparam int IDX_SPAN   = 1 << IDX_W;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_data;

    checked_handle_table #(
        .MAX_ENTRIES(TABLE_SIZE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // configuration as last written, shared by the generator and the model
    logic [TYPE_W-1:0]   cfg_type = '0;
    logic [HANDLE_W-1:0] cfg_salt = '0;

    // table model, advanced at acceptance
    int               tbl_count = 0;
    logic [TAG_W-1:0] tbl_tags [TABLE_SIZE];

    // generator view of the table, advanced as words are queued
    int               gen_count = 0;
    logic [TAG_W-1:0] gen_tags [TABLE_SIZE];

    t_in_word  request_q[$];
    t_out_word response_q[$];

    int  err_count = 0;
    bit  in_taken = 1'b0;
    bit  calm = 1'b0;
    int  calm_left = 150;
    int  gap_left = 0;
    int  stall_left = 0;

    // raw handle layout with parity, salted
    function automatic logic [HANDLE_W-1:0] pack_handle(logic [IDX_W-1:0] idx,
                                                        logic [TYPE_W-1:0] typ,
                                                        logic [TAG_W-1:0] tag);
        logic [HANDLE_W-1:0] h;
        h = {1'b0, tag, typ, idx};
        h[PARITY_BIT] = ^h[PARITY_BIT-1:0];
        return h ^ cfg_salt;
    endfunction

    // expected response for one request, updates the table model
    function automatic t_out_word table_response(t_in_word w);
        t_out_word           r;
        logic [HANDLE_W-1:0] h;
        logic [IDX_W-1:0]    idx;
        logic [TAG_W-1:0]    tag;
        r = '0;
        case (w.mode)
            MODE_ADD: begin
                if (tbl_count >= TABLE_SIZE) begin
                    r.status = ST_FULL;
                end else begin
                    tag = (w.new_tag == '0) ? TAG_W'(1) : w.new_tag;
                    tbl_tags[tbl_count] = tag;
                    h = {1'b0, tag, cfg_type, IDX_W'(tbl_count)};
                    h[PARITY_BIT] = ^h[PARITY_BIT-1:0];
                    r.handle_out = h ^ cfg_salt;
                    r.index_out  = OUTIDX_W'(tbl_count);
                    tbl_count++;
                end
            end
            MODE_CHECK: begin
                h   = w.handle_in ^ cfg_salt;
                idx = h[IDX_W-1:0];
                if (w.handle_in == '0)
                    r.status = ST_NULL;
                else if (h[PARITY_BIT] != ^h[PARITY_BIT-1:0])
                    r.status = ST_PARITY;
                else if (h[TAG_LSB-1:TYPE_LSB] != cfg_type)
                    r.status = ST_TYPE;
                else if (idx >= tbl_count || idx >= TABLE_SIZE)
                    r.status = ST_RANGE;
                else if (tbl_tags[idx] != h[PARITY_BIT-1:TAG_LSB])
                    r.status = ST_TAG;
                else
                    r.index_out = idx[OUTIDX_W-1:0];
            end
            MODE_CLEAR: begin
                tbl_count = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // request queueing, with the generator view kept in step
    task automatic queue_word(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] h,
                              logic [TAG_W-1:0] tag);
        t_in_word w;
        w.mode      = mode;
        w.handle_in = h;
        w.new_tag   = tag;
        if (mode == MODE_ADD && gen_count < TABLE_SIZE) begin
            gen_tags[gen_count] = (tag == '0) ? TAG_W'(1) : tag;
            gen_count++;
        end
        if (mode == MODE_CLEAR)
            gen_count = 0;
        request_q = {request_q, w};
    endtask

    function automatic logic [TAG_W-1:0] rand_tag();
        return ($urandom_range(9) == 0) ? '0 : TAG_W'($urandom_range(127));
    endfunction

    task automatic queue_add(logic [TAG_W-1:0] tag);
        queue_word(MODE_ADD, $urandom, tag);
    endtask

    task automatic queue_check(logic [HANDLE_W-1:0] h);
        queue_word(MODE_CHECK, h, TAG_W'($urandom));
    endtask

    // validate word: good handles for two in five, the rest flawed or random
    task automatic queue_rand_check();
        int r;
        int idx;
        r   = $urandom_range(99);
        idx = (gen_count > 0) ? $urandom_range(gen_count - 1) : 0;
        if (r < 40 && gen_count > 0)
            queue_check(pack_handle(IDX_W'(idx), cfg_type, gen_tags[idx]));
        else if (r < 50 && gen_count > 0)
            queue_check(pack_handle(IDX_W'(idx), cfg_type,
                                    gen_tags[idx] ^ TAG_W'($urandom_range(127, 1))));
        else if (r < 58)
            queue_check(pack_handle(IDX_W'(idx), cfg_type ^ TYPE_W'($urandom_range(63, 1)),
                                    rand_tag()));
        else if (r < 66)
            queue_check(pack_handle(IDX_W'(idx), cfg_type, gen_tags[idx])
                        ^ (32'h1 << $urandom_range(31)));
        else if (r < 74) begin
            if ($urandom_range(1) == 0)
                idx = gen_count;
            else
                idx = $urandom_range(IDX_SPAN - 1, gen_count);
            queue_check(pack_handle(IDX_W'(idx), cfg_type, rand_tag()));
        end else if (r < 78)
            queue_check('0);
        else if (r < 82)
            queue_check(cfg_salt);
        else
            queue_check($urandom);
    endtask

    task automatic queue_rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            queue_add(rand_tag());
        else if (r < 90)
            queue_rand_check();
        else if (r < 97)
            queue_word(MODE_CLEAR, $urandom, TAG_W'($urandom));
        else
            queue_word(MODE_UNUSED, $urandom, TAG_W'($urandom));
    endtask

    // wait until every queued word is accepted and answered
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (request_q.size() > 0 || i_in_valid || response_q.size() > 0);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OBJECT_TYPE: cfg_type = data[TYPE_W-1:0];
            CFG_HANDLE_SALT: cfg_salt = data;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // idle between phases, then load a new setting
    task automatic load_setting(logic [TYPE_W-1:0] typ, logic [HANDLE_W-1:0] salt);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_OBJECT_TYPE, CFG_DATA_W'(typ));
        write_reg(CFG_HANDLE_SALT, salt);
    endtask

    function automatic int pick_len();
        return ($urandom_range(9) < 8) ? $urandom_range(3, 1) : $urandom_range(30, 10);
    endfunction

    task automatic report_word(string what, t_out_word exp_w, t_out_word got_w);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s: expected status %0d handle %h index %0d, %s %0d handle %h index %0d",
                     what, exp_w.status, exp_w.handle_out, exp_w.index_out,
                     "got status", got_w.status, got_w.handle_out, got_w.index_out);
    endtask

    // request driver, next word at the falling edge
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                i_in_data  <= request_q.pop_front();
                i_in_valid <= 1'b1;
                gap_left   = (calm || $urandom_range(99) < 55) ? 0 : pick_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(99) < 25) begin
            stall_left = pick_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // acceptance and response checking at the rising edge
    always @(posedge i_clk) begin : sample_blk
        t_out_word exp_w;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            exp_w      = table_response(i_in_data);
            response_q = {response_q, exp_w};
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (response_q.size() == 0) begin
                report_word("unexpected word", '0, o_out_data);
            end else begin
                exp_w = response_q.pop_front();
                if (o_out_data.status != exp_w.status
                        || o_out_data.handle_out != exp_w.handle_out
                        || o_out_data.index_out != exp_w.index_out)
                    report_word("mismatch", exp_w, o_out_data);
            end
        end
        // alternate stretches with and without idling
        if (calm_left > 0) begin
            calm_left--;
        end else begin
            calm      = !calm;
            calm_left = $urandom_range(400, 100);
        end
    end

    // stimulus
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset setting: type 0, no salt
        queue_check('0);
        queue_check(pack_handle(0, 0, 1));
        queue_add('0);
        queue_add(7'h7f);
        queue_add(TAG_W'($urandom_range(126, 1)));
        queue_check(pack_handle(0, 0, 1));
        queue_check(pack_handle(1, 0, 7'h7f));
        queue_check(pack_handle(1, 0, 7'h3f));
        queue_check(pack_handle(0, 6'h3f, 1));
        queue_check(pack_handle(0, 0, 1) ^ 32'h8000_0000);
        queue_check(pack_handle(3, 0, 1));
        queue_check(pack_handle(IDX_SPAN - 1, 0, 1));
        queue_check(32'hffff_ffff);
        queue_word(MODE_UNUSED, $urandom, TAG_W'($urandom));
        queue_check(pack_handle(2, 0, gen_tags[2]));
        queue_word(MODE_CLEAR, $urandom, TAG_W'($urandom));
        queue_check(pack_handle(0, 0, 1));
        queue_add(7'h55);
        queue_check(pack_handle(0, 0, 7'h55));

        // all-ones type and salt
        load_setting(6'h3f, 32'hffff_ffff);
        queue_add(7'h2a);
        queue_check(pack_handle(1, 6'h3f, 7'h2a));
        queue_check(pack_handle(0, 6'h3f, 7'h55));
        queue_check('0);
        queue_check(cfg_salt);
        queue_check(pack_handle(0, 6'h00, 7'h55));
        repeat (150) queue_rand_word();
        // sender holds off until the table has answered everything
        wait_drained();
        repeat (150) queue_rand_word();

        // random setting, fill the table to the limit
        load_setting(TYPE_W'($urandom), $urandom);
        queue_word(MODE_CLEAR, $urandom, TAG_W'($urandom));
        while (gen_count < TABLE_SIZE) begin
            if ($urandom_range(19) == 0)
                queue_rand_check();
            else
                queue_add(rand_tag());
        end
        queue_add('0);
        queue_check(pack_handle(TABLE_SIZE - 1, cfg_type, gen_tags[TABLE_SIZE - 1]));
        queue_check(pack_handle(TABLE_SIZE, cfg_type, 1));
        queue_check(pack_handle(0, cfg_type, gen_tags[0]));
        repeat (60) begin
            if ($urandom_range(99) < 40)
                queue_add(rand_tag());
            else
                queue_rand_check();
        end
        queue_word(MODE_CLEAR, $urandom, TAG_W'($urandom));

        // type 0 with a random salt
        load_setting('0, $urandom);
        repeat (250) queue_rand_word();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (response_q.size() > 0)
            err_count++;
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/cht_pkg.sv
design/cht_ram.sv
design/cht_eval.sv
design/checked_handle_table.sv
dv/tb_checked_handle_table.sv
